>>> src/rkf_pkg.sv
// Shared types and constants for the RGBA 3x3 kernel filter.
// No dependencies; imported by rkf_window, rkf_arith and the top level.
`default_nettype none

package rkf_pkg;

  typedef logic [31:0] pixel_t;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;
    logic       frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [7:0]  out_alpha;
    logic [11:0] out_row;
    logic [10:0] out_col;
    logic        frame_last;
  } pix_out_t;

  // Per-request control travelling alongside the window pipeline
  typedef struct packed {
    logic        emit;
    logic        last;
    logic [11:0] row;
    logic [10:0] col;
  } ctrl_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 36;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_WEIGHTS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ALPHA   = 2'd3;

  localparam logic [11:0] WIDTH_RESET   = 12'd640;
  localparam logic [12:0] HEIGHT_RESET  = 13'd480;
  localparam logic [35:0] WEIGHTS_RESET = 36'h111111111;

  localparam int TAPS  = 9;
  localparam int SUM_W = 16;

  // floor(x/9) == (x * 58255) >> 19 for every x below 2^16
  localparam logic [15:0] DIV9_MUL   = 16'd58255;
  localparam int          DIV9_SHIFT = 19;

  function automatic logic [7:0] div9_sat(input logic [SUM_W-1:0] sum);
    logic [31:0] prod;
    logic [12:0] quo;
    prod = 32'(sum) * 32'(DIV9_MUL);
    quo  = prod[DIV9_SHIFT +: 13];
    return (quo > 13'd255) ? 8'hff : quo[7:0];
  endfunction

endpackage

`default_nettype wire

>>> src/rkf_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Registered read data that holds while no read is issued. No dependencies.
`default_nettype none

module rkf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> src/rkf_window.sv
// Line store and 3x3 window: read-modify-write of the two-line RAM with
// same-column forwarding. Depends on rkf_pkg and rkf_ram.
`default_nettype none

module rkf_window
  import rkf_pkg::*;
#(
  parameter int MAX_WIDTH = 2048,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          adv_i,
  input  wire logic          acc_i,
  input  wire logic [CW-1:0] acc_col_i,
  input  wire pixel_t        acc_pix_i,
  input  wire logic          s1_valid_i,
  output pixel_t             window_o [TAPS]
);

  logic [CW-1:0] s1_col_q;
  pixel_t        s1_pix_q;
  logic          fwd_q;
  logic [63:0]   fwd_data_q;
  logic [63:0]   rdata;
  logic [63:0]   line;
  logic [63:0]   wdata;
  logic          we;
  logic          hit;
  pixel_t        win_q [TAPS];

  // entry: [63:32] line above, [31:0] line two above
  assign line  = fwd_q ? fwd_data_q : rdata;
  assign wdata = {s1_pix_q, line[63:32]};
  assign we    = adv_i && s1_valid_i;
  assign hit   = acc_i && s1_valid_i && (s1_col_q == acc_col_i);

  rkf_ram #(
    .WIDTH(64),
    .DEPTH(MAX_WIDTH)
  ) u_lines (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(s1_col_q),
    .wdata_i(wdata),
    .re_i   (acc_i),
    .raddr_i(acc_col_i),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_col_q   <= acc_col_i;
      s1_pix_q   <= acc_pix_i;
      fwd_data_q <= wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
      for (int k = 0; k < TAPS; k++) begin
        win_q[k] <= '0;
      end
    end else begin
      if (acc_i) begin
        fwd_q <= hit;
      end
      if (we) begin
        for (int r = 0; r < 3; r++) begin
          win_q[r*3]   <= win_q[r*3+1];
          win_q[r*3+1] <= win_q[r*3+2];
        end
        win_q[2] <= line[31:0];
        win_q[5] <= line[63:32];
        win_q[8] <= s1_pix_q;
      end
    end
  end

  assign window_o = win_q;

endmodule

`default_nettype wire

>>> src/rkf_arith.sv
// Weighted 3x3 sums per channel, then divide by 9 and saturate (alpha is the centre pixel's
// alpha when filter_alpha_i is low). Two register stages, both advancing on adv_i. Depends on rkf_pkg.
`default_nettype none

module rkf_arith
  import rkf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        adv_i,
  input  wire pixel_t      window_i [TAPS],
  input  wire logic [35:0] weights_i,
  input  wire logic        filter_alpha_i,
  output pixel_t           result_o
);

  logic [SUM_W-1:0] sum_d [4];
  logic [SUM_W-1:0] sum_q [4];
  logic [7:0]       centre_alpha_q;
  pixel_t           result_q;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sum_d[c] = '0;
      for (int k = 0; k < TAPS; k++) begin
        sum_d[c] = sum_d[c] + SUM_W'(weights_i[4*k +: 4]) * SUM_W'(window_i[k][8*c +: 8]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sum_q          <= sum_d;
      centre_alpha_q <= window_i[4][31:24];
      result_q[7:0]   <= div9_sat(sum_q[0]);
      result_q[15:8]  <= div9_sat(sum_q[1]);
      result_q[23:16] <= div9_sat(sum_q[2]);
      result_q[31:24] <= filter_alpha_i ? div9_sat(sum_q[3]) : centre_alpha_q;
    end
  end

  assign result_o = result_q;

endmodule

`default_nettype wire

>>> src/rgba_3x3_kernel_filter.sv
// Top level of the RGBA 3x3 kernel filter: position counters, configuration
// registers and request pipeline. Depends on rkf_pkg, rkf_window, rkf_arith.
//
// Takes one RGBA pixel per clock in raster order and, once two full rows and
// two columns have arrived, returns one filtered pixel per interior position
// with its row and column, through the s1, window, sum and result registers;
// throughput is one pixel per cycle, set by the single read and single write
// per cycle of the two-line RAM (MAX_WIDTH entries of 64 bits) that is read
// on input and written back from s1. A stall on a valid output holds the
// whole pipeline and is passed back to the input in the same cycle.
// Configuration may be written only while no pixel is in flight.
`default_nettype none

module rgba_3x3_kernel_filter
  import rkf_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire pix_in_t               in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output pix_out_t                   out_data_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [11:0]   width_q;
  logic [12:0]   height_q;
  logic [35:0]   weights_q;
  logic          filter_alpha_q;

  logic [CW-1:0] col_q, col_d, col_cur;
  logic [RW-1:0] row_q, row_d, row_cur;
  logic [CW:0]   w_eff;
  logic [RW:0]   h_eff;
  logic          col_end, row_end;

  logic          adv, acc;
  ctrl_t         ctrl_new;
  logic          s1_valid_q;
  ctrl_t         s1_ctrl_q, s2_ctrl_q, s3_ctrl_q, out_ctrl_q;
  logic          out_valid_q;

  pixel_t        window [TAPS];
  pixel_t        result;

  assign adv        = !out_valid_q || !out_stall_i;
  assign acc        = in_valid_i && adv;
  assign in_stall_o = !adv;

  always_comb begin
    if (32'(width_q) < 32'd3) begin
      w_eff = (CW+1)'(3);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      w_eff = (CW+1)'(MAX_WIDTH);
    end else begin
      w_eff = (CW+1)'(width_q);
    end
    if (32'(height_q) < 32'd3) begin
      h_eff = (RW+1)'(3);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      h_eff = (RW+1)'(MAX_HEIGHT);
    end else begin
      h_eff = (RW+1)'(height_q);
    end
  end

  always_comb begin
    col_cur = in_data_i.frame_start ? '0 : col_q;
    row_cur = in_data_i.frame_start ? '0 : row_q;
    col_end = ({1'b0, col_cur} + (CW+1)'(1)) >= w_eff;
    row_end = ({1'b0, row_cur} + (RW+1)'(1)) >= h_eff;
    if (col_end) begin
      col_d = '0;
      row_d = row_end ? '0 : row_cur + RW'(1);
    end else begin
      col_d = col_cur + CW'(1);
      row_d = row_cur;
    end
    ctrl_new.emit = (32'(row_cur) >= 32'd2) && (32'(col_cur) >= 32'd2);
    ctrl_new.last = row_end && col_end;
    ctrl_new.row  = 12'(32'(row_cur) - 32'd1);
    ctrl_new.col  = 11'(32'(col_cur) - 32'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q        <= WIDTH_RESET;
      height_q       <= HEIGHT_RESET;
      weights_q      <= WEIGHTS_RESET;
      filter_alpha_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_IMAGE_WIDTH:    width_q        <= cfg_data_i[11:0];
        CFG_IMAGE_HEIGHT:   height_q       <= cfg_data_i[12:0];
        CFG_KERNEL_WEIGHTS: weights_q      <= cfg_data_i[35:0];
        CFG_FILTER_ALPHA:   filter_alpha_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      s1_valid_q  <= 1'b0;
      s1_ctrl_q   <= '0;
      s2_ctrl_q   <= '0;
      s3_ctrl_q   <= '0;
      out_ctrl_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (adv) begin
        s1_valid_q  <= acc;
        s1_ctrl_q   <= ctrl_new;
        s2_ctrl_q   <= '{emit: s1_valid_q && s1_ctrl_q.emit, last: s1_ctrl_q.last,
                         row: s1_ctrl_q.row, col: s1_ctrl_q.col};
        s3_ctrl_q   <= s2_ctrl_q;
        out_ctrl_q  <= s3_ctrl_q;
        out_valid_q <= s3_ctrl_q.emit;
      end
    end
  end

  rkf_window #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .acc_i     (acc),
    .acc_col_i (col_cur),
    .acc_pix_i ({in_data_i.in_alpha, in_data_i.in_blue,
                 in_data_i.in_green, in_data_i.in_red}),
    .s1_valid_i(s1_valid_q),
    .window_o  (window)
  );

  rkf_arith u_arith (
    .clk_i         (clk_i),
    .adv_i         (adv),
    .window_i      (window),
    .weights_i     (weights_q),
    .filter_alpha_i(filter_alpha_q),
    .result_o      (result)
  );

  assign out_valid_o           = out_valid_q;
  assign out_data_o.out_red    = result[7:0];
  assign out_data_o.out_green  = result[15:8];
  assign out_data_o.out_blue   = result[23:16];
  assign out_data_o.out_alpha  = result[31:24];
  assign out_data_o.out_row    = out_ctrl_q.row;
  assign out_data_o.out_col    = out_ctrl_q.col;
  assign out_data_o.frame_last = out_ctrl_q.last;

endmodule

`default_nettype wire
